// ===== sv/ccpp_pkg.sv =====
// types and constants shared by the constant pool parser
// parse phase, tag codes, result kinds and the result record
// depends on nothing
`default_nettype none

package ccpp_pkg;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_COUNT,
        PH_TAG,
        PH_FIELDS,
        PH_TLEN,
        PH_TEXT,
        PH_HALT
    } phase_t;

    typedef enum logic [2:0] {
        KIND_FIXED = 3'd0,
        KIND_THEAD = 3'd1,
        KIND_TBYTE = 3'd2,
        KIND_EMPTY = 3'd3,
        KIND_ERROR = 3'd4
    } kind_t;

    localparam logic [7:0] TAG_UTF8   = 8'd1;
    localparam logic [7:0] TAG_INT    = 8'd3;
    localparam logic [7:0] TAG_CLASS  = 8'd7;
    localparam logic [7:0] TAG_FIELD  = 8'd9;
    localparam logic [7:0] TAG_METHOD = 8'd10;
    localparam logic [7:0] TAG_NAT    = 8'd12;

    // field byte counts of the fixed-size entries
    localparam logic [2:0] FIELD_BYTES_SHORT = 3'd2;
    localparam logic [2:0] FIELD_BYTES_LONG  = 3'd4;

    localparam int unsigned M_TDATA_W = 104;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] entry_index;
        logic [7:0]  tag;
        logic [15:0] first_index;
        logic [15:0] second_index;
        logic [31:0] int_value;
        logic [7:0]  text_byte;
        logic        text_end;
        logic        pool_end;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/class_constant_pool_parser.sv =====
// class-file constant pool parser, top level
// byte stream in, one record per finished entry or text byte out
// depends on ccpp_pkg
`default_nettype none

// Takes a constant pool one byte per transfer and accepts a byte in every
// cycle while s_tready is high. A byte with s_tuser high restarts the parser
// and is the high count byte; the pool then holds count minus one entries.
// Each entry gives records: fixed entries (Integer, Class, FieldRef, MethodRef,
// NameAndType) one record, Utf8 entries a header record with the length and
// then one record per text byte. A count of one gives an empty-pool record; a
// count of zero or an unknown tag gives an error record and the parser ignores
// bytes until the next restart. m_tlast marks the final record of the pool.
// The result side has an output register and a skid register, so s_tready only
// drops when both hold records that downstream has not taken.
module class_constant_pool_parser (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input stream
    input  wire logic                          s_tvalid,
    output      logic                          s_tready,
    input  wire logic [7:0]                    s_tdata,  // [7:0] in_byte
    input  wire logic                          s_tuser,  // [0] start_pool
    // result stream
    output      logic                          m_tvalid,
    input  wire logic                          m_tready,
    // [15:0] entry_index, [23:16] tag, [39:24] first_index,
    // [55:40] second_index, [87:56] int_value, [95:88] text_byte,
    // [96] text_end, [103:97] zero
    output      logic [ccpp_pkg::M_TDATA_W-1:0] m_tdata,
    output      logic [2:0]                    m_tuser,  // [2:0] kind
    output      logic                          m_tlast   // pool_end
);

    // parser state
    ccpp_pkg::phase_t phase_reg, phase_next;
    logic [2:0]       field_byte_count_reg, field_byte_count_next;
    logic [7:0]       current_tag_reg, current_tag_next;
    logic [15:0]      entries_total_reg, entries_total_next;
    logic [15:0]      entry_number_reg, entry_number_next;
    logic [15:0]      text_left_reg, text_left_next;
    logic [31:0]      field_shift_reg, field_shift_next;

    // output register and skid register
    logic              out_valid_reg, out_valid_next;
    ccpp_pkg::result_t out_data_reg, out_data_next;
    logic              skid_valid_reg, skid_valid_next;
    ccpp_pkg::result_t skid_data_reg, skid_data_next;

    // record from the current byte
    logic              res_valid;
    ccpp_pkg::result_t res;

    logic        s_accept;
    logic        m_pop;
    logic        push;
    logic [7:0]  in_byte;
    logic        start_pool;
    logic [31:0] shift_in;       // accumulator with the new byte shifted in
    logic [2:0]  count_inc;
    logic [15:0] pool_count;
    logic [15:0] entry_inc;
    logic [15:0] text_dec;
    logic        last_entry;     // current entry is the final one
    logic        tag_known;
    logic [2:0]  field_need;

    assign in_byte    = s_tdata;
    assign start_pool = s_tuser;
    assign s_tready   = !skid_valid_reg;
    assign s_accept   = s_tvalid && s_tready;
    assign m_pop      = out_valid_reg && m_tready;
    assign push       = s_accept && res_valid;

    assign shift_in   = {field_shift_reg[23:0], in_byte};
    assign count_inc  = field_byte_count_reg + 3'd1;
    assign pool_count = {field_shift_reg[7:0], in_byte};
    assign entry_inc  = entry_number_reg + 16'd1;
    assign text_dec   = text_left_reg - 16'd1;
    assign last_entry = entry_number_reg >= entries_total_reg;

    always_comb begin
        tag_known = in_byte inside {ccpp_pkg::TAG_INT, ccpp_pkg::TAG_CLASS,
                                    ccpp_pkg::TAG_FIELD, ccpp_pkg::TAG_METHOD,
                                    ccpp_pkg::TAG_NAT};
        if (current_tag_reg inside {ccpp_pkg::TAG_INT, ccpp_pkg::TAG_FIELD,
                                    ccpp_pkg::TAG_METHOD, ccpp_pkg::TAG_NAT}) begin
            field_need = ccpp_pkg::FIELD_BYTES_LONG;
        end else begin
            field_need = ccpp_pkg::FIELD_BYTES_SHORT;
        end
    end

    // next state of the parser
    always_comb begin
        phase_next            = phase_reg;
        field_byte_count_next = field_byte_count_reg;
        current_tag_next      = current_tag_reg;
        entries_total_next    = entries_total_reg;
        entry_number_next     = entry_number_reg;
        text_left_next        = text_left_reg;
        field_shift_next      = field_shift_reg;

        if (s_accept) begin
            if (start_pool) begin
                // restart: drop everything, keep the high count byte
                phase_next            = ccpp_pkg::PH_COUNT;
                field_byte_count_next = 3'd0;
                current_tag_next      = 8'd0;
                entries_total_next    = 16'd0;
                entry_number_next     = 16'd0;
                text_left_next        = 16'd0;
                field_shift_next      = {24'd0, in_byte};
            end else begin
                case (phase_reg)
                    ccpp_pkg::PH_COUNT: begin
                        field_shift_next   = 32'd0;
                        entries_total_next = pool_count - 16'd1;
                        entry_number_next  = 16'd0;
                        if (pool_count == 16'd0) begin
                            phase_next = ccpp_pkg::PH_HALT;
                        end else if (pool_count == 16'd1) begin
                            phase_next = ccpp_pkg::PH_IDLE;
                        end else begin
                            phase_next = ccpp_pkg::PH_TAG;
                        end
                    end
                    ccpp_pkg::PH_TAG: begin
                        entry_number_next     = entry_inc;
                        current_tag_next      = in_byte;
                        field_shift_next      = 32'd0;
                        field_byte_count_next = 3'd0;
                        if (in_byte == ccpp_pkg::TAG_UTF8) begin
                            phase_next = ccpp_pkg::PH_TLEN;
                        end else if (tag_known) begin
                            phase_next = ccpp_pkg::PH_FIELDS;
                        end else begin
                            phase_next = ccpp_pkg::PH_HALT;
                        end
                    end
                    ccpp_pkg::PH_FIELDS: begin
                        if (count_inc < field_need) begin
                            field_shift_next      = shift_in;
                            field_byte_count_next = count_inc;
                        end else begin
                            field_shift_next      = 32'd0;
                            field_byte_count_next = 3'd0;
                            phase_next = last_entry ? ccpp_pkg::PH_IDLE : ccpp_pkg::PH_TAG;
                        end
                    end
                    ccpp_pkg::PH_TLEN: begin
                        if (count_inc < ccpp_pkg::FIELD_BYTES_SHORT) begin
                            field_shift_next      = shift_in;
                            field_byte_count_next = count_inc;
                        end else begin
                            field_shift_next      = 32'd0;
                            field_byte_count_next = 3'd0;
                            text_left_next        = shift_in[15:0];
                            if (shift_in[15:0] != 16'd0) begin
                                phase_next = ccpp_pkg::PH_TEXT;
                            end else begin
                                phase_next = last_entry ? ccpp_pkg::PH_IDLE
                                                        : ccpp_pkg::PH_TAG;
                            end
                        end
                    end
                    ccpp_pkg::PH_TEXT: begin
                        text_left_next = text_dec;
                        if (text_dec == 16'd0) begin
                            phase_next = last_entry ? ccpp_pkg::PH_IDLE : ccpp_pkg::PH_TAG;
                        end
                    end
                    default: begin
                        // idle or halted: bytes are dropped
                    end
                endcase
            end
        end
    end

    // record produced by the current byte
    always_comb begin
        res_valid = 1'b0;
        res       = '0;
        if (!start_pool) begin
            case (phase_reg)
                ccpp_pkg::PH_COUNT: begin
                    if (pool_count == 16'd0) begin
                        res_valid    = 1'b1;
                        res.kind     = ccpp_pkg::KIND_ERROR;
                        res.pool_end = 1'b1;
                    end else if (pool_count == 16'd1) begin
                        res_valid    = 1'b1;
                        res.kind     = ccpp_pkg::KIND_EMPTY;
                        res.pool_end = 1'b1;
                    end
                end
                ccpp_pkg::PH_TAG: begin
                    if (in_byte != ccpp_pkg::TAG_UTF8 && !tag_known) begin
                        res_valid       = 1'b1;
                        res.kind        = ccpp_pkg::KIND_ERROR;
                        res.entry_index = entry_inc;
                        res.tag         = in_byte;
                        res.pool_end    = 1'b1;
                    end
                end
                ccpp_pkg::PH_FIELDS: begin
                    if (count_inc >= field_need) begin
                        res_valid       = 1'b1;
                        res.kind        = ccpp_pkg::KIND_FIXED;
                        res.entry_index = entry_number_reg;
                        res.tag         = current_tag_reg;
                        res.pool_end    = last_entry;
                        if (current_tag_reg == ccpp_pkg::TAG_INT) begin
                            res.int_value = shift_in;
                        end else if (current_tag_reg == ccpp_pkg::TAG_CLASS) begin
                            res.first_index = shift_in[15:0];
                        end else begin
                            res.first_index  = shift_in[31:16];
                            res.second_index = shift_in[15:0];
                        end
                    end
                end
                ccpp_pkg::PH_TLEN: begin
                    if (count_inc >= ccpp_pkg::FIELD_BYTES_SHORT) begin
                        res_valid       = 1'b1;
                        res.kind        = ccpp_pkg::KIND_THEAD;
                        res.entry_index = entry_number_reg;
                        res.tag         = current_tag_reg;
                        res.first_index = shift_in[15:0];
                        // empty text closes the entry on the header
                        res.pool_end    = (shift_in[15:0] == 16'd0) && last_entry;
                    end
                end
                ccpp_pkg::PH_TEXT: begin
                    res_valid       = 1'b1;
                    res.kind        = ccpp_pkg::KIND_TBYTE;
                    res.entry_index = entry_number_reg;
                    res.tag         = current_tag_reg;
                    res.text_byte   = in_byte;
                    res.text_end    = text_dec == 16'd0;
                    res.pool_end    = (text_dec == 16'd0) && last_entry;
                end
                default: begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    // output register with skid stage; pushes only arrive while the skid is empty
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (push) begin
            if (!out_valid_reg || m_pop) begin
                out_valid_next = 1'b1;
                out_data_next  = res;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = res;
            end
        end else if (m_pop) begin
            if (skid_valid_reg) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg            <= ccpp_pkg::PH_IDLE;
            field_byte_count_reg <= 3'd0;
            current_tag_reg      <= 8'd0;
            entries_total_reg    <= 16'd0;
            entry_number_reg     <= 16'd0;
            text_left_reg        <= 16'd0;
            field_shift_reg      <= 32'd0;
            out_valid_reg        <= 1'b0;
            skid_valid_reg       <= 1'b0;
        end else begin
            phase_reg            <= phase_next;
            field_byte_count_reg <= field_byte_count_next;
            current_tag_reg      <= current_tag_next;
            entries_total_reg    <= entries_total_next;
            entry_number_reg     <= entry_number_next;
            text_left_reg        <= text_left_next;
            field_shift_reg      <= field_shift_next;
            out_valid_reg        <= out_valid_next;
            skid_valid_reg       <= skid_valid_next;
        end
    end

    // record payload needs no reset
    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_data_reg.kind;
    assign m_tlast  = out_data_reg.pool_end;
    assign m_tdata  = {7'd0,
                       out_data_reg.text_end,
                       out_data_reg.text_byte,
                       out_data_reg.int_value,
                       out_data_reg.second_index,
                       out_data_reg.first_index,
                       out_data_reg.tag,
                       out_data_reg.entry_index};

`ifndef NO_ASSERTIONS
    // skid only fills behind a held output record
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a record while output is empty");

    // an error record halts the parser unless a restart comes
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && res.kind == ccpp_pkg::KIND_ERROR) |=> phase_reg == ccpp_pkg::PH_HALT)
        else $error("parser not halted after an error record");

    // text counter is empty outside a text payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != ccpp_pkg::PH_TEXT) |-> text_left_reg == 16'd0)
        else $error("text byte counter left nonzero outside text payload");

    // field byte count never reaches the longest field size
    assert property (@(posedge aclk) disable iff (!aresetn)
        field_byte_count_reg < ccpp_pkg::FIELD_BYTES_LONG)
        else $error("field byte count out of range");
`endif

endmodule

`default_nettype wire
